@@ hdl/spae_pkg.sv @@
// Shared types, codes and constants of the sparse polynomial accumulate/evaluate block.
package spae_pkg;

	localparam int MAX_EXP_DEF   = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int COEF_W = 32;
	localparam int EXP_W  = 4;
	localparam int X_W    = 32;
	localparam int ACC_W  = 64;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef struct packed {
		logic                     opcode;
		logic signed [COEF_W-1:0] term_coefficient;
		logic        [EXP_W-1:0]  term_exponent;
		logic signed [X_W-1:0]    x_value;
	} req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] poly_value;
		logic                    saturated;
	} res_t;

	typedef struct packed {
		logic clear;
		logic mul_lo;
		logic mul_hi;
		logic combine;
		logic accum;
	} mac_ctl_t;

endpackage

@@ hdl/spae_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module spae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/spae_mac.sv @@
// Horner step unit: split 64x32 multiply, floor shift, saturation and coefficient add.
module spae_mac import spae_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  mac_ctl_t                 ctl,
	input  logic signed [X_W-1:0]    x_value,
	input  logic signed [COEF_W-1:0] coef,
	output logic signed [ACC_W-1:0]  acc,
	output logic                     sat
);

	localparam int PROD_W = ACC_W + X_W;
	localparam int HALF_W = ACC_W / 2;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [ACC_W-1:0]  plo_q;
	logic signed [ACC_W-1:0]  phi_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [HALF_W:0]        opa;
	logic signed [HALF_W+X_W:0]    mult;
	logic signed [PROD_W-1:0]      prod_sum;
	logic signed [PROD_W-1:0]      shifted;
	logic                          ovf_mul;
	logic        [ACC_W-1:0]       prod_sat;
	logic        [ACC_W:0]         add_sum;
	logic                          ovf_add;
	logic        [ACC_W-1:0]       acc_next;

	assign opa = ctl.mul_hi ? {acc_q[ACC_W-1], acc_q[ACC_W-1:HALF_W]}
	                        : {1'b0, acc_q[HALF_W-1:0]};
	assign mult = opa * x_q;

	assign prod_sum = {phi_q[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}}
	                + {{(PROD_W-ACC_W){plo_q[ACC_W-1]}}, plo_q};

	assign shifted = prod_q >>> FRAC_BITS;
	assign ovf_mul = !((&shifted[PROD_W-1:ACC_W-1]) || !(|shifted[PROD_W-1:ACC_W-1]));
	assign prod_sat = ovf_mul ? (shifted[PROD_W-1] ? ACC_MIN : ACC_MAX)
	                          : shifted[ACC_W-1:0];

	assign add_sum = {prod_sat[ACC_W-1], prod_sat}
	               + {{(ACC_W-COEF_W+1){coef[COEF_W-1]}}, coef};
	assign ovf_add = add_sum[ACC_W] ^ add_sum[ACC_W-1];
	assign acc_next = ovf_add ? (add_sum[ACC_W] ? ACC_MIN : ACC_MAX) : add_sum[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
			x_q   <= x_value;
		end
		if (ctl.mul_lo) begin
			plo_q <= mult[ACC_W-1:0];
		end
		if (ctl.mul_hi) begin
			phi_q <= mult[ACC_W-1:0];
		end
		if (ctl.combine) begin
			prod_q <= prod_sum;
		end
		if (ctl.accum) begin
			acc_q <= acc_next;
		end
	end

	assign acc = acc_q;
	assign sat = ctl.accum && (ovf_mul || ovf_add);

endmodule

@@ hdl/sparse_poly_accumulate_eval_core.sv @@
// Top level: coefficient table, request sequencer, Horner evaluation and result register.
// An add request reads the table entry, then writes back the saturating sum; out-of-range adds leave the table as is.
// An evaluate request passes each table entry through four steps of the MAC unit (low product,
// high product, combine, shift/saturate/add), between accepting the request and loading the result.
// One request is in work at a time; a finished result waits in the output register while the next
// request is accepted. Reset clears the per-entry valid bits and sticky flag at once; no sweep.
module sparse_poly_accumulate_eval_core import spae_pkg::*; #(
	parameter int MAX_EXP   = MAX_EXP_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	localparam int AW = $clog2(MAX_EXP);
	localparam int IW = (AW > EXP_W) ? AW : EXP_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ADD_WR  = 3'd1;
	localparam logic [2:0] ST_EV_LO   = 3'd2;
	localparam logic [2:0] ST_EV_HI   = 3'd3;
	localparam logic [2:0] ST_EV_CMB  = 3'd4;
	localparam logic [2:0] ST_EV_ACC  = 3'd5;
	localparam logic [2:0] ST_EV_DONE = 3'd6;

	logic [2:0]               state_q;
	logic [MAX_EXP-1:0]       valid_q;
	logic                     sat_q;
	logic                     res_valid_q;
	res_t                     res_q;
	logic [AW-1:0]            idx_q;
	logic signed [COEF_W-1:0] coef_q;
	logic                     coef_vld_q;

	logic                     accept;
	logic [IW-1:0]            exp_wide;
	logic [AW-1:0]            exp_idx;
	logic                     in_range;
	logic                     ram_we;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [COEF_W-1:0]        ram_rdata;
	logic signed [COEF_W-1:0] coef_rd;
	logic [COEF_W:0]          add_sum;
	logic                     add_ovf;
	logic [COEF_W-1:0]        add_val;
	logic                     res_load;
	mac_ctl_t                 mac_ctl;
	logic signed [ACC_W-1:0]  mac_acc;
	logic                     mac_sat;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign exp_wide  = IW'(req_data.term_exponent);
	assign exp_idx   = exp_wide[AW-1:0];
	assign in_range  = int'(req_data.term_exponent) < MAX_EXP;

	assign ram_raddr = (state_q == ST_IDLE) ? exp_idx : idx_q;
	assign ram_re    = (accept && req_data.opcode == OP_ADD && in_range) || state_q == ST_EV_LO;
	assign ram_we    = (state_q == ST_ADD_WR);
	assign coef_rd   = coef_vld_q ? $signed(ram_rdata) : '0;

	assign add_sum = {coef_rd[COEF_W-1], coef_rd} + {coef_q[COEF_W-1], coef_q};
	assign add_ovf = add_sum[COEF_W] ^ add_sum[COEF_W-1];
	assign add_val = add_ovf ? (add_sum[COEF_W] ? COEF_MIN : COEF_MAX) : add_sum[COEF_W-1:0];

	assign res_load = (state_q == ST_EV_DONE) && (!res_valid_q || !res_stall);

	always_comb begin
		mac_ctl         = '0;
		mac_ctl.clear   = accept && req_data.opcode == OP_EVAL;
		mac_ctl.mul_lo  = (state_q == ST_EV_LO);
		mac_ctl.mul_hi  = (state_q == ST_EV_HI);
		mac_ctl.combine = (state_q == ST_EV_CMB);
		mac_ctl.accum   = (state_q == ST_EV_ACC);
	end

	spae_ram #(
		.WIDTH(COEF_W),
		.DEPTH(MAX_EXP)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(add_val),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	spae_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.x_value(req_data.x_value),
		.coef   (coef_rd),
		.acc    (mac_acc),
		.sat    (mac_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_data.opcode == OP_EVAL) begin
							state_q <= ST_EV_LO;
						end else if (in_range) begin
							state_q <= ST_ADD_WR;
						end
					end
				end
				ST_ADD_WR: begin
					valid_q[idx_q] <= 1'b1;
					if (add_ovf) begin
						sat_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_EV_LO:  state_q <= ST_EV_HI;
				ST_EV_HI:  state_q <= ST_EV_CMB;
				ST_EV_CMB: state_q <= ST_EV_ACC;
				ST_EV_ACC: begin
					if (mac_sat) begin
						sat_q <= 1'b1;
					end
					state_q <= (idx_q == '0) ? ST_EV_DONE : ST_EV_LO;
				end
				ST_EV_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			coef_vld_q <= valid_q[ram_raddr];
		end
		if (accept) begin
			if (req_data.opcode == OP_EVAL) begin
				idx_q <= AW'(MAX_EXP - 1);
			end else begin
				idx_q <= exp_idx;
			end
			coef_q <= req_data.term_coefficient;
		end else if (state_q == ST_EV_ACC && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (res_load) begin
			res_q.poly_value <= mac_acc;
			res_q.saturated  <= sat_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ hdl/spae_checker.sv @@
// Port-level checker for the polynomial core, bound to the top level.
module spae_checker import spae_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_data,
	input logic res_valid,
	input logic res_stall,
	input res_t res_data
);

	logic sat_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_seen_q <= 1'b0;
		end else if (res_valid && !res_stall && res_data.saturated) begin
			sat_seen_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed or dropped");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sat_seen_q |-> res_data.saturated)
		else $error("saturation flag cleared after being reported");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.opcode == OP_EVAL |=> req_stall ##1 req_stall)
		else $error("evaluate request did not hold off the next request");

	a_res_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_stall))
		else $error("result appeared without an evaluation in progress");

endmodule

bind sparse_poly_accumulate_eval_core spae_checker u_spae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req_data (req_data),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);
